/* design/ihsr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the I2C humidity sensor reader.
// No dependencies; used by the sequencer, the conversion stages and the top level.
package ihsr_pkg;

  typedef enum logic [13:0] {
    PhIdle     = 14'b00000000000001,
    PhStart1   = 14'b00000000000010,
    PhStart2   = 14'b00000000000100,
    PhTxLow    = 14'b00000000001000,
    PhTxHigh   = 14'b00000000010000,
    PhAckLow   = 14'b00000000100000,
    PhAckWait  = 14'b00000001000000,
    PhRxLow    = 14'b00000010000000,
    PhRxHigh   = 14'b00000100000000,
    PhMackLow  = 14'b00001000000000,
    PhMackHigh = 14'b00010000000000,
    PhStop1    = 14'b00100000000000,
    PhStop2    = 14'b01000000000000,
    PhStop3    = 14'b10000000000000
  } phase_e;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic {
    CfgHalfPeriod = 1'b0,
    CfgAckTimeout = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic scl_low;
    logic sda_low;
    logic busy;
    logic done;
    logic nack;
  } status_t;

  localparam logic [15:0] HalfPeriodReset = 16'd100;
  localparam logic [15:0] AckTimeoutReset = 16'd256;
  localparam logic [7:0]  AddrReadBit     = 8'h01;
  localparam logic [14:0] TempScale       = 15'd17500;
  localparam logic [13:0] HumScale        = 14'd10000;
  localparam logic [15:0] RoundBias       = 16'd32767;
  localparam logic [14:0] TempOffset      = 15'd4500;

endpackage

/* design/ihsr_seq.sv */
`timescale 1ns / 1ps
// Bus phase sequencer: one step per accepted tick, config registers, read byte capture.
// Depends on ihsr_pkg.
module ihsr_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [1:0]              op_i,
  input  logic [7:0]              dev_addr_i,
  input  logic [7:0]              cmd_high_i,
  input  logic [7:0]              cmd_low_i,
  input  logic                    sda_in_i,
  input  logic                    scl_in_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  output ihsr_pkg::status_t       status_o,
  output logic [15:0]             temp_raw_o,
  output logic [15:0]             hum_raw_o
);

  ihsr_pkg::phase_e phase_q, phase_d;
  logic [15:0] half_q, ack_to_q;
  logic [15:0] timer_q, timer_d;
  logic [15:0] ack_cnt_q, ack_cnt_d;
  logic [3:0]  bit_q, bit_d;
  logic [2:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [7:0]  rb_q [4];
  logic [7:0]  rb_d [4];
  logic        is_read_q, is_read_d;
  logic        nack_q, nack_d;
  logic        done_q, done_d;

  logic [15:0] hp, lim, timer_adv, cnt_inc;
  logic        hit, timeout, after_ack;
  logic [3:0]  bit_inc;
  logic [2:0]  byte_inc;
  logic [7:0]  shift_rx;

  assign hp        = (half_q == 16'd0) ? 16'd1 : half_q;
  assign lim       = (ack_to_q == 16'd0) ? 16'd1 : ack_to_q;
  assign hit       = ({1'b0, timer_q} + 17'd1) >= {1'b0, hp};
  assign timer_adv = hit ? 16'd0 : timer_q + 16'd1;
  assign cnt_inc   = (ack_cnt_q != 16'hFFFF) ? ack_cnt_q + 16'd1 : ack_cnt_q;
  assign timeout   = cnt_inc >= lim;
  assign bit_inc   = bit_q + 4'd1;
  assign byte_inc  = byte_q + 3'd1;
  assign shift_rx  = {shift_q[6:0], sda_in_i};

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    ack_cnt_d = ack_cnt_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    pend_d    = pend_q;
    rb_d      = rb_q;
    is_read_d = is_read_q;
    nack_d    = nack_q;
    done_d    = done_q;
    after_ack = 1'b0;
    if (step_i) begin
      done_d = 1'b0;
      unique case (phase_q)
        ihsr_pkg::PhIdle: begin
          if (op_i == ihsr_pkg::OpWrite || op_i == ihsr_pkg::OpRead) begin
            is_read_d = (op_i == ihsr_pkg::OpRead);
            pend_d[0] = (op_i == ihsr_pkg::OpRead) ? (dev_addr_i | ihsr_pkg::AddrReadBit)
                                                   : dev_addr_i;
            pend_d[1] = cmd_high_i;
            pend_d[2] = cmd_low_i;
            byte_d    = 3'd0;
            bit_d     = 4'd0;
            nack_d    = 1'b0;
            ack_cnt_d = 16'd0;
            timer_d   = 16'd0;
            shift_d   = pend_d[0];
            phase_d   = ihsr_pkg::PhStart1;
          end
        end
        ihsr_pkg::PhStart1: begin
          timer_d = timer_adv;
          if (hit) phase_d = ihsr_pkg::PhStart2;
        end
        ihsr_pkg::PhStart2: begin
          timer_d = timer_adv;
          if (hit) begin
            bit_d   = 4'd0;
            phase_d = ihsr_pkg::PhTxLow;
          end
        end
        ihsr_pkg::PhTxLow: begin
          timer_d = timer_adv;
          if (hit) phase_d = ihsr_pkg::PhTxHigh;
        end
        ihsr_pkg::PhTxHigh: begin
          timer_d = timer_adv;
          if (hit) begin
            bit_d   = bit_inc;
            shift_d = {shift_q[6:0], 1'b0};
            if (bit_inc >= 4'd8) begin
              ack_cnt_d = 16'd0;
              phase_d   = ihsr_pkg::PhAckLow;
            end else begin
              phase_d = ihsr_pkg::PhTxLow;
            end
          end
        end
        ihsr_pkg::PhAckLow: begin
          timer_d = timer_adv;
          if (hit) begin
            ack_cnt_d = 16'd0;
            phase_d   = ihsr_pkg::PhAckWait;
          end
        end
        ihsr_pkg::PhAckWait: begin
          if (!sda_in_i) begin
            after_ack = 1'b1;
          end else begin
            ack_cnt_d = cnt_inc;
            if (timeout) begin
              nack_d = 1'b1;
              if (is_read_q) begin
                timer_d = 16'd0;
                phase_d = ihsr_pkg::PhStop1;
              end else begin
                after_ack = 1'b1;
              end
            end
          end
        end
        ihsr_pkg::PhRxLow: begin
          timer_d = timer_adv;
          if (hit) phase_d = ihsr_pkg::PhRxHigh;
        end
        ihsr_pkg::PhRxHigh: begin
          if (scl_in_i) begin
            timer_d = timer_adv;
            if (hit) begin
              shift_d = shift_rx;
              bit_d   = bit_inc;
              if (bit_inc >= 4'd8) begin
                case (byte_q)
                  3'd0:    rb_d[0] = shift_rx;
                  3'd1:    rb_d[1] = shift_rx;
                  3'd3:    rb_d[2] = shift_rx;
                  3'd4:    rb_d[3] = shift_rx;
                  default: ;
                endcase
                phase_d = ihsr_pkg::PhMackLow;
              end else begin
                phase_d = ihsr_pkg::PhRxLow;
              end
            end
          end
        end
        ihsr_pkg::PhMackLow: begin
          timer_d = timer_adv;
          if (hit) phase_d = ihsr_pkg::PhMackHigh;
        end
        ihsr_pkg::PhMackHigh: begin
          timer_d = timer_adv;
          if (hit) begin
            byte_d = byte_inc;
            if (byte_inc < 3'd6) begin
              bit_d   = 4'd0;
              shift_d = 8'd0;
              phase_d = ihsr_pkg::PhRxLow;
            end else begin
              phase_d = ihsr_pkg::PhStop1;
            end
          end
        end
        ihsr_pkg::PhStop1: begin
          timer_d = timer_adv;
          if (hit) phase_d = ihsr_pkg::PhStop2;
        end
        ihsr_pkg::PhStop2: begin
          timer_d = timer_adv;
          if (hit) phase_d = ihsr_pkg::PhStop3;
        end
        ihsr_pkg::PhStop3: begin
          timer_d = timer_adv;
          if (hit) begin
            phase_d = ihsr_pkg::PhIdle;
            done_d  = 1'b1;
          end
        end
        default: begin
          phase_d = ihsr_pkg::PhIdle;
          timer_d = 16'd0;
        end
      endcase
      if (after_ack) begin
        timer_d = 16'd0;
        bit_d   = 4'd0;
        if (is_read_q) begin
          byte_d  = 3'd0;
          shift_d = 8'd0;
          phase_d = ihsr_pkg::PhRxLow;
        end else begin
          byte_d = byte_inc;
          if (byte_inc < 3'd3) begin
            shift_d = pend_q[byte_inc[1:0]];
            phase_d = ihsr_pkg::PhTxLow;
          end else begin
            phase_d = ihsr_pkg::PhStop1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= ihsr_pkg::HalfPeriodReset;
      ack_to_q <= ihsr_pkg::AckTimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ihsr_pkg::CfgHalfPeriod: half_q   <= cfg_data_i;
        ihsr_pkg::CfgAckTimeout: ack_to_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ihsr_pkg::PhIdle;
      timer_q   <= 16'd0;
      ack_cnt_q <= 16'd0;
      bit_q     <= 4'd0;
      byte_q    <= 3'd0;
      shift_q   <= 8'd0;
      pend_q    <= '{default: 8'd0};
      rb_q      <= '{default: 8'd0};
      is_read_q <= 1'b0;
      nack_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      ack_cnt_q <= ack_cnt_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      shift_q   <= shift_d;
      pend_q    <= pend_d;
      rb_q      <= rb_d;
      is_read_q <= is_read_d;
      nack_q    <= nack_d;
      done_q    <= done_d;
    end
  end

  always_comb begin
    status_o.scl_low = (phase_q == ihsr_pkg::PhTxLow) || (phase_q == ihsr_pkg::PhAckLow) ||
                       (phase_q == ihsr_pkg::PhRxLow) || (phase_q == ihsr_pkg::PhMackLow) ||
                       (phase_q == ihsr_pkg::PhStop1);
    if (phase_q == ihsr_pkg::PhStart2 || phase_q == ihsr_pkg::PhStop1 ||
        phase_q == ihsr_pkg::PhStop2) begin
      status_o.sda_low = 1'b1;
    end else if (phase_q == ihsr_pkg::PhTxLow || phase_q == ihsr_pkg::PhTxHigh) begin
      status_o.sda_low = ~shift_q[7];
    end else if (phase_q == ihsr_pkg::PhMackLow || phase_q == ihsr_pkg::PhMackHigh) begin
      status_o.sda_low = byte_q < 3'd5;
    end else begin
      status_o.sda_low = 1'b0;
    end
    status_o.busy = phase_q != ihsr_pkg::PhIdle;
    status_o.done = done_q;
    status_o.nack = done_q & nack_q;
  end

  assign temp_raw_o = {rb_q[0], rb_q[1]};
  assign hum_raw_o  = {rb_q[2], rb_q[3]};

endmodule

/* design/ihsr_conv.sv */
`timescale 1ns / 1ps
// Two result stages: scale products, then divide by 65535 and offset; holds the output register.
// Depends on ihsr_pkg.
module ihsr_conv (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic                    valid_i,
  input  ihsr_pkg::status_t       status_i,
  input  logic [15:0]             temp_raw_i,
  input  logic [15:0]             hum_raw_i,
  output logic                    valid_o,
  output ihsr_pkg::status_t       status_o,
  output logic [15:0]             temp_raw_o,
  output logic [15:0]             hum_raw_o,
  output logic signed [14:0]      temp_centi_o,
  output logic [13:0]             hum_centi_o
);

  logic              v2_q;
  ihsr_pkg::status_t st2_q;
  logic [15:0]       traw2_q, hraw2_q;
  logic [30:0]       tprod_d, tprod_q;
  logic [29:0]       hprod_d, hprod_q;

  logic [31:0]       tsum;
  logic [30:0]       hsum;
  logic [14:0]       tq;

  logic              v3_q;
  ihsr_pkg::status_t st3_q;
  logic [15:0]       traw3_q, hraw3_q;
  logic [14:0]       tc3_q;
  logic [13:0]       hc3_q;

  assign tprod_d = 31'(ihsr_pkg::TempScale) * 31'(temp_raw_i) + 31'(ihsr_pkg::RoundBias);
  assign hprod_d = 30'(ihsr_pkg::HumScale) * 30'(hum_raw_i) + 30'(ihsr_pkg::RoundBias);

  assign tsum = 32'(tprod_q) + 32'(tprod_q[30:16]) + 32'd1;
  assign hsum = 31'(hprod_q) + 31'(hprod_q[29:16]) + 31'd1;
  assign tq   = tsum[30:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      st2_q   <= status_i;
      traw2_q <= temp_raw_i;
      hraw2_q <= hum_raw_i;
      tprod_q <= tprod_d;
      hprod_q <= hprod_d;
      st3_q   <= st2_q;
      traw3_q <= traw2_q;
      hraw3_q <= hraw2_q;
      tc3_q   <= tq - ihsr_pkg::TempOffset;
      hc3_q   <= hsum[29:16];
    end
  end

  assign valid_o      = v3_q;
  assign status_o     = st3_q;
  assign temp_raw_o   = traw3_q;
  assign hum_raw_o    = hraw3_q;
  assign temp_centi_o = signed'(tc3_q);
  assign hum_centi_o  = hc3_q;

endmodule

/* design/i2c_humidity_sensor_reader_core.sv */
`timescale 1ns / 1ps
// Top level of the I2C humidity sensor reader: handshake, sequencer and result stages.
// Depends on ihsr_pkg, ihsr_seq and ihsr_conv.

// Each input transfer is one clock tick of the I2C bus master and yields exactly one result
// transfer. A tick is taken every cycle while the output side keeps up; the result passes
// through the sequencer state, the scale product stage and the divide and offset stage,
// and the pipeline stalls as a whole when the output is stalled. Op 1 writes address, command
// high and command low bytes; op 2 reads six bytes and reports raw and converted temperature
// and humidity; requests while busy are ignored. Bus timing is counted in ticks, so one SCL
// half phase lasts the half period setting in ticks. Write configuration only while idle.
module i2c_humidity_sensor_reader_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         dev_addr_i,
  input  logic [7:0]         cmd_high_i,
  input  logic [7:0]         cmd_low_i,
  input  logic               sda_in_i,
  input  logic               scl_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               scl_pull_low_o,
  output logic               sda_pull_low_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               nack_error_o,
  output logic [15:0]        temp_raw_o,
  output logic [15:0]        hum_raw_o,
  output logic signed [14:0] temp_centi_o,
  output logic [13:0]        hum_centi_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic              advance, step, v1_q;
  ihsr_pkg::status_t seq_status, out_status;
  logic [15:0]       seq_traw, seq_hraw;

  assign advance     = ~out_valid_o | ~out_stall_i;
  assign in_stall_o  = ~advance;
  assign step        = in_valid_i & advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_valid_i;
    end
  end

  ihsr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .op_i        (op_i),
    .dev_addr_i  (dev_addr_i),
    .cmd_high_i  (cmd_high_i),
    .cmd_low_i   (cmd_low_i),
    .sda_in_i    (sda_in_i),
    .scl_in_i    (scl_in_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (seq_status),
    .temp_raw_o  (seq_traw),
    .hum_raw_o   (seq_hraw)
  );

  ihsr_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .valid_i      (v1_q),
    .status_i     (seq_status),
    .temp_raw_i   (seq_traw),
    .hum_raw_i    (seq_hraw),
    .valid_o      (out_valid_o),
    .status_o     (out_status),
    .temp_raw_o   (temp_raw_o),
    .hum_raw_o    (hum_raw_o),
    .temp_centi_o (temp_centi_o),
    .hum_centi_o  (hum_centi_o)
  );

  assign scl_pull_low_o = out_status.scl_low;
  assign sda_pull_low_o = out_status.sda_low;
  assign busy_res_o     = out_status.busy;
  assign done_res_o     = out_status.done;
  assign nack_error_o   = out_status.nack;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  a_nack_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nack_error_o |-> done_res_o)
    else $error("nack reported outside end of transfer");

  a_idle_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !scl_pull_low_o && !sda_pull_low_o)
    else $error("bus lines driven while idle");

endmodule

/* bench/i2c_humidity_sensor_reader_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for i2c_humidity_sensor_reader_core: directed ticks, then emulated sensor
// transfers under several bus timings, each result checked against a cycle-exact bus model.
// Depends on ihsr_pkg and the design sources; reads no files.
module i2c_humidity_sensor_reader_core_tb;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 8;

  typedef struct packed {
    ihsr_pkg::op_e op;
    logic [7:0]    dev;
    logic [7:0]    cmd_hi;
    logic [7:0]    cmd_lo;
    logic          sda;
    logic          scl;
  } tick_t;

  typedef struct packed {
    ihsr_pkg::status_t st;
    logic [15:0]       t_raw;
    logic [15:0]       h_raw;
    logic [14:0]       t_centi;
    logic [13:0]       h_centi;
  } reading_t;

  typedef struct {
    bit                  cfg_en;
    ihsr_pkg::cfg_idx_e  cfg_idx;
    logic [15:0]         cfg_val;
    tick_t               item;
    int                  reps;
    bit                  typed;
  } stim_row_t;

  // Idle with nothing read yet: raw words zero, temperature at its -45.00 C floor.
  localparam reading_t IdleReading = '{st: '0, t_raw: '0, h_raw: '0, t_centi: 15'h6E6C,
                                       h_centi: '0};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         op_i;
  logic [7:0]         dev_addr_i;
  logic [7:0]         cmd_high_i;
  logic [7:0]         cmd_low_i;
  logic               sda_in_i;
  logic               scl_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               scl_pull_low_o;
  logic               sda_pull_low_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic               nack_error_o;
  logic [15:0]        temp_raw_o;
  logic [15:0]        hum_raw_o;
  logic signed [14:0] temp_centi_o;
  logic [13:0]        hum_centi_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [15:0]        cfg_data_i;

  i2c_humidity_sensor_reader_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .dev_addr_i     (dev_addr_i),
    .cmd_high_i     (cmd_high_i),
    .cmd_low_i      (cmd_low_i),
    .sda_in_i       (sda_in_i),
    .scl_in_i       (scl_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_pull_low_o (scl_pull_low_o),
    .sda_pull_low_o (sda_pull_low_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .nack_error_o   (nack_error_o),
    .temp_raw_o     (temp_raw_o),
    .hum_raw_o      (hum_raw_o),
    .temp_centi_o   (temp_centi_o),
    .hum_centi_o    (hum_centi_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Bus model state and its copy of the registers.
  ihsr_pkg::phase_e bus_phase;
  logic [15:0] half_timer;
  logic [15:0] ack_count;
  logic [3:0]  bit_cnt;
  logic [2:0]  byte_cnt;
  logic [7:0]  shreg;
  logic [7:0]  tx_bytes [3];
  logic [7:0]  rx_bytes [6];
  logic        reading;
  logic        nack_flag;
  logic [15:0] half_period;
  logic [15:0] ack_timeout;

  // Emulated sensor behavior for the transfer in flight.
  logic [7:0]  sensor_bytes [6];
  int          ack_hold;
  int          stretch_pct;
  bit          noisy;

  reading_t    reading_q [$];
  reading_t    oldest;
  int          send_pct;
  int          recv_pct;
  int          errors;
  int          ticks_sent;
  int          writes_done;
  int          reads_done;
  int          timeouts;
  int          settings_written;
  int          cycle_count = 0;

  stim_row_t stim_rows [7] = '{
    '{1'b0, ihsr_pkg::CfgHalfPeriod, 16'd0,
      '{ihsr_pkg::OpTick, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}, 1, 1'b1},
    '{1'b0, ihsr_pkg::CfgHalfPeriod, 16'd0,
      '{ihsr_pkg::OpNone, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1, 1'b1},
    '{1'b1, ihsr_pkg::CfgAckTimeout, 16'd0,
      '{ihsr_pkg::OpTick, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1, 1'b1},
    '{1'b1, ihsr_pkg::CfgHalfPeriod, 16'd0,
      '{ihsr_pkg::OpWrite, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0}, 1, 1'b0},
    '{1'b0, ihsr_pkg::CfgHalfPeriod, 16'd0,
      '{ihsr_pkg::OpRead, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1}, 1, 1'b0},
    '{1'b0, ihsr_pkg::CfgHalfPeriod, 16'd0,
      '{ihsr_pkg::OpNone, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}, 1, 1'b0},
    '{1'b0, ihsr_pkg::CfgHalfPeriod, 16'd0,
      '{ihsr_pkg::OpTick, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b1}, 18, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("i2c_humidity_sensor_reader_core_tb: FAIL");
      $finish;
    end
  end

  task automatic model_reset();
    bus_phase   = ihsr_pkg::PhIdle;
    half_timer  = '0;
    ack_count   = '0;
    bit_cnt     = '0;
    byte_cnt    = '0;
    shreg       = '0;
    reading     = 1'b0;
    nack_flag   = 1'b0;
    half_period = ihsr_pkg::HalfPeriodReset;
    ack_timeout = ihsr_pkg::AckTimeoutReset;
    foreach (tx_bytes[i]) tx_bytes[i] = '0;
    foreach (rx_bytes[i]) rx_bytes[i] = '0;
  endtask

  function automatic bit half_done();
    logic [16:0] limit;
    limit = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
    if ({1'b0, half_timer} + 17'd1 >= limit) begin
      half_timer = '0;
      return 1'b1;
    end
    half_timer = half_timer + 16'd1;
    return 1'b0;
  endfunction

  function automatic void after_ack();
    half_timer = '0;
    bit_cnt    = '0;
    if (reading) begin
      byte_cnt  = '0;
      shreg     = '0;
      bus_phase = ihsr_pkg::PhRxLow;
    end else begin
      byte_cnt = byte_cnt + 3'd1;
      if (byte_cnt < 3'd3) begin
        shreg     = tx_bytes[byte_cnt[1:0]];
        bus_phase = ihsr_pkg::PhTxLow;
      end else begin
        bus_phase = ihsr_pkg::PhStop1;
      end
    end
  endfunction

  function automatic reading_t next_reading(tick_t t);
    reading_t    r;
    logic        done;
    logic [16:0] limit;
    logic [15:0] traw;
    logic [15:0] hraw;
    logic [31:0] tq;
    logic [31:0] hq;
    done = 1'b0;
    case (bus_phase)
      ihsr_pkg::PhIdle: begin
        if (t.op == ihsr_pkg::OpWrite || t.op == ihsr_pkg::OpRead) begin
          reading     = (t.op == ihsr_pkg::OpRead);
          tx_bytes[0] = reading ? (t.dev | ihsr_pkg::AddrReadBit) : t.dev;
          tx_bytes[1] = t.cmd_hi;
          tx_bytes[2] = t.cmd_lo;
          byte_cnt    = '0;
          bit_cnt     = '0;
          nack_flag   = 1'b0;
          ack_count   = '0;
          half_timer  = '0;
          shreg       = tx_bytes[0];
          bus_phase   = ihsr_pkg::PhStart1;
        end
      end
      ihsr_pkg::PhStart1: if (half_done()) bus_phase = ihsr_pkg::PhStart2;
      ihsr_pkg::PhStart2: begin
        if (half_done()) begin
          bit_cnt   = '0;
          bus_phase = ihsr_pkg::PhTxLow;
        end
      end
      ihsr_pkg::PhTxLow: if (half_done()) bus_phase = ihsr_pkg::PhTxHigh;
      ihsr_pkg::PhTxHigh: begin
        if (half_done()) begin
          bit_cnt = bit_cnt + 4'd1;
          shreg   = {shreg[6:0], 1'b0};
          if (bit_cnt >= 4'd8) begin
            ack_count = '0;
            bus_phase = ihsr_pkg::PhAckLow;
          end else begin
            bus_phase = ihsr_pkg::PhTxLow;
          end
        end
      end
      ihsr_pkg::PhAckLow: begin
        if (half_done()) begin
          ack_count = '0;
          bus_phase = ihsr_pkg::PhAckWait;
        end
      end
      ihsr_pkg::PhAckWait: begin
        if (!t.sda) begin
          after_ack();
        end else begin
          limit = (ack_timeout == 16'd0) ? 17'd1 : {1'b0, ack_timeout};
          if (ack_count != 16'hFFFF) ack_count = ack_count + 16'd1;
          if ({1'b0, ack_count} >= limit) begin
            nack_flag = 1'b1;
            if (reading) begin
              half_timer = '0;
              bus_phase  = ihsr_pkg::PhStop1;
            end else begin
              after_ack();
            end
          end
        end
      end
      ihsr_pkg::PhRxLow: if (half_done()) bus_phase = ihsr_pkg::PhRxHigh;
      ihsr_pkg::PhRxHigh: begin
        if (t.scl) begin
          if (half_done()) begin
            shreg   = {shreg[6:0], t.sda};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              if (byte_cnt < 3'd6) rx_bytes[byte_cnt] = shreg;
              bus_phase = ihsr_pkg::PhMackLow;
            end else begin
              bus_phase = ihsr_pkg::PhRxLow;
            end
          end
        end
      end
      ihsr_pkg::PhMackLow: if (half_done()) bus_phase = ihsr_pkg::PhMackHigh;
      ihsr_pkg::PhMackHigh: begin
        if (half_done()) begin
          byte_cnt = byte_cnt + 3'd1;
          if (byte_cnt < 3'd6) begin
            bit_cnt   = '0;
            shreg     = '0;
            bus_phase = ihsr_pkg::PhRxLow;
          end else begin
            bus_phase = ihsr_pkg::PhStop1;
          end
        end
      end
      ihsr_pkg::PhStop1: if (half_done()) bus_phase = ihsr_pkg::PhStop2;
      ihsr_pkg::PhStop2: if (half_done()) bus_phase = ihsr_pkg::PhStop3;
      ihsr_pkg::PhStop3: begin
        if (half_done()) begin
          bus_phase = ihsr_pkg::PhIdle;
          done      = 1'b1;
        end
      end
      default: begin
        bus_phase  = ihsr_pkg::PhIdle;
        half_timer = '0;
      end
    endcase

    r.st.scl_low = (bus_phase == ihsr_pkg::PhTxLow || bus_phase == ihsr_pkg::PhAckLow ||
                    bus_phase == ihsr_pkg::PhRxLow || bus_phase == ihsr_pkg::PhMackLow ||
                    bus_phase == ihsr_pkg::PhStop1);
    if (bus_phase == ihsr_pkg::PhStart2 || bus_phase == ihsr_pkg::PhStop1 ||
        bus_phase == ihsr_pkg::PhStop2)
      r.st.sda_low = 1'b1;
    else if (bus_phase == ihsr_pkg::PhTxLow || bus_phase == ihsr_pkg::PhTxHigh)
      r.st.sda_low = ~shreg[7];
    else if (bus_phase == ihsr_pkg::PhMackLow || bus_phase == ihsr_pkg::PhMackHigh)
      r.st.sda_low = (byte_cnt < 3'd5);
    else
      r.st.sda_low = 1'b0;
    r.st.busy = (bus_phase != ihsr_pkg::PhIdle);
    r.st.done = done;
    r.st.nack = done & nack_flag;

    traw = {rx_bytes[0], rx_bytes[1]};
    hraw = {rx_bytes[3], rx_bytes[4]};
    tq = (32'd17500 * traw + 32'd32767) / 32'd65535;
    hq = (32'd10000 * hraw + 32'd32767) / 32'd65535;
    r.t_raw   = traw;
    r.h_raw   = hraw;
    r.t_centi = 15'(tq - 32'd4500);
    r.h_centi = 14'(hq);
    return r;
  endfunction

  // Sensor side of one bus tick: ack and data where the bus expects them, noise elsewhere.
  function automatic tick_t bus_tick();
    tick_t t;
    t.op     = ihsr_pkg::op_e'($urandom_range(3));
    t.dev    = 8'($urandom);
    t.cmd_hi = 8'($urandom);
    t.cmd_lo = 8'($urandom);
    t.sda    = 1'($urandom_range(1));
    t.scl    = 1'($urandom_range(1));
    if (bus_phase == ihsr_pkg::PhAckWait) begin
      t.sda = (ack_count < ack_hold);
    end else if (bus_phase == ihsr_pkg::PhRxHigh && !noisy) begin
      t.scl = ($urandom_range(99) >= stretch_pct);
      t.sda = sensor_bytes[byte_cnt][3'd7 - bit_cnt[2:0]];
    end
    return t;
  endfunction

  task automatic arm_sensor(input logic [15:0] ato);
    int eff;
    eff = (ato == 16'd0) ? 1 : int'(ato);
    if ($urandom_range(99) < 12 && eff <= 300)
      ack_hold = 'hFFFF;
    else
      ack_hold = $urandom_range(3);
    case ($urandom_range(2))
      0: stretch_pct = 0;
      1: stretch_pct = 20;
      default: stretch_pct = 60;
    endcase
    noisy = ($urandom_range(9) == 0);
    foreach (sensor_bytes[i]) sensor_bytes[i] = 8'($urandom);
    case ($urandom_range(3))
      0: {sensor_bytes[0], sensor_bytes[1]} = 16'h0000;
      1: {sensor_bytes[0], sensor_bytes[1]} = 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(3))
      0: {sensor_bytes[3], sensor_bytes[4]} = 16'h0000;
      1: {sensor_bytes[3], sensor_bytes[4]} = 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic push_tick(input tick_t t, input bit typed);
    reading_t r;
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= t.op;
    dev_addr_i <= t.dev;
    cmd_high_i <= t.cmd_hi;
    cmd_low_i  <= t.cmd_lo;
    sda_in_i   <= t.sda;
    scl_in_i   <= t.scl;
    do @(posedge clk_i); while (in_stall_o);
    r = next_reading(t);
    reading_q.push_back(typed ? IdleReading : r);
    ticks_sent++;
    if (r.st.done) begin
      if (reading) reads_done++;
      else writes_done++;
      if (r.st.nack) timeouts++;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input ihsr_pkg::cfg_idx_e idx, input logic [15:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == ihsr_pkg::CfgHalfPeriod) half_period = value;
    else ack_timeout = value;
    settings_written++;
  endtask

  task automatic run_phase(input logic [15:0] hp, input logic [15:0] ato, input int budget,
                           input int send_idle, input int recv_idle, input bit requests);
    int    first;
    bit    calm;
    tick_t t;
    write_reg(ihsr_pkg::CfgHalfPeriod, hp);
    write_reg(ihsr_pkg::CfgAckTimeout, ato);
    first = ticks_sent;
    while (ticks_sent - first < budget) begin
      calm     = ($urandom_range(3) == 0);
      send_pct = calm ? 0 : send_idle;
      recv_pct = calm ? 0 : recv_idle;
      repeat ($urandom_range(4, requests ? 0 : 1)) begin
        t     = bus_tick();
        t.op  = $urandom_range(1) ? ihsr_pkg::OpTick : ihsr_pkg::OpNone;
        push_tick(t, 1'b0);
      end
      if (requests) begin
        arm_sensor(ato);
        t    = bus_tick();
        t.op = ($urandom_range(4) < 2) ? ihsr_pkg::OpWrite : ihsr_pkg::OpRead;
        push_tick(t, 1'b0);
        while (bus_phase != ihsr_pkg::PhIdle) push_tick(bus_tick(), 1'b0);
      end
    end
    drain_results();
  endtask

  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reading_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none expected, actual busy %0b done %0b", $time,
                 busy_res_o, done_res_o);
      end else begin
        oldest = reading_q.pop_front();
        check_field("scl_pull_low", oldest.st.scl_low, scl_pull_low_o);
        check_field("sda_pull_low", oldest.st.sda_low, sda_pull_low_o);
        check_field("busy_res", oldest.st.busy, busy_res_o);
        check_field("done_res", oldest.st.done, done_res_o);
        check_field("nack_error", oldest.st.nack, nack_error_o);
        check_field("temp_raw", oldest.t_raw, temp_raw_o);
        check_field("hum_raw", oldest.h_raw, hum_raw_o);
        check_field("temp_centi", $signed(oldest.t_centi), temp_centi_o);
        check_field("hum_centi", oldest.h_centi, hum_centi_o);
      end
    end
  end

  initial begin
    errors           = 0;
    ticks_sent       = 0;
    writes_done      = 0;
    reads_done       = 0;
    timeouts         = 0;
    settings_written = 0;
    send_pct         = 0;
    recv_pct         = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    op_i        <= ihsr_pkg::OpTick;
    dev_addr_i  <= '0;
    cmd_high_i  <= '0;
    cmd_low_i   <= '0;
    sda_in_i    <= 1'b1;
    scl_in_i    <= 1'b1;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= ihsr_pkg::CfgHalfPeriod;
    cfg_data_i  <= '0;
    model_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pct = 37;
    recv_pct = 75;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].cfg_en) write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_val);
      repeat (stim_rows[i].reps) push_tick(stim_rows[i].item, stim_rows[i].typed);
    end
    // finish the open write with a sensor that acks at once
    ack_hold    = 0;
    stretch_pct = 0;
    noisy       = 1'b0;
    while (bus_phase != ihsr_pkg::PhIdle) push_tick(bus_tick(), 1'b0);

    run_phase(16'd1, 16'd4, 300, 37, 75, 1'b1);
    run_phase(16'd2, 16'hFFFF, 250, 75, 37, 1'b1);
    run_phase(16'd3, 16'd2, 150, 0, 0, 1'b1);
    run_phase(16'd1, 16'd1, 120, 0, 0, 1'b1);
    run_phase(16'hFFFF, ihsr_pkg::AckTimeoutReset, 30, 0, 0, 1'b0);
    drain_results();

    $display("Drove %0d bus ticks over %0d register writes: %0d writes and %0d reads done.",
             ticks_sent, settings_written, writes_done, reads_done);
    $display("%0d transfers ended with an ack timeout; %0d field mismatches.", timeouts, errors);
    if (errors == 0) begin
      $display("i2c_humidity_sensor_reader_core_tb: PASS");
    end else begin
      $display("i2c_humidity_sensor_reader_core_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ihsr_pkg.sv
design/ihsr_seq.sv
design/ihsr_conv.sv
design/i2c_humidity_sensor_reader_core.sv
bench/i2c_humidity_sensor_reader_core_tb.sv
